@@ rtl/dtig_pkg.sv @@
// Dome triangle index generator: shared package.
// Word layouts, register indexes and default sizes. No dependencies.
`default_nettype none

package dtig_pkg;

  localparam int MAX_SIDES_DEF  = 64;
  localparam int MAX_LEVELS_DEF = 32;

  localparam int SIDES_W  = 7;
  localparam int LEVELS_W = 6;
  localparam int CFG_W    = 7;
  localparam int IDX_W    = 16;

  localparam logic [SIDES_W-1:0]  SIDES_RESET  = 7'd16;
  localparam logic [LEVELS_W-1:0] LEVELS_RESET = 6'd8;

  // Register indexes on the configuration port
  localparam logic REG_SIDES  = 1'b0;
  localparam logic REG_LEVELS = 1'b1;

  // Operation codes carried in op
  localparam logic OP_ADVANCE = 1'b0;
  localparam logic OP_START   = 1'b1;

  typedef struct packed {
    logic             op;
    logic             pass;
    logic [IDX_W-1:0] first_slot;
  } in_word_t;

  typedef struct packed {
    logic [IDX_W-1:0] idx_a;
    logic [IDX_W-1:0] idx_b;
    logic [IDX_W-1:0] idx_c;
    logic [IDX_W-1:0] idx_d;
    logic [IDX_W-1:0] idx_e;
    logic [IDX_W-1:0] idx_f;
    logic             group_size;
    logic [IDX_W-1:0] slot;
    logic             last;
  } out_word_t;

endpackage

`default_nettype wire

@@ rtl/dtig_walk.sv @@
// Dome triangle index generator: walk state, configuration registers and
// group arithmetic. Depends on dtig_pkg.
`default_nettype none

module dtig_walk #(
  parameter int MAX_SIDES  = dtig_pkg::MAX_SIDES_DEF,
  parameter int MAX_LEVELS = dtig_pkg::MAX_LEVELS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_wr_en,
  input  wire logic                          cfg_index,
  input  wire logic [dtig_pkg::CFG_W-1:0]    cfg_data,
  input  wire logic                          step,
  input  wire dtig_pkg::in_word_t            in_word,
  output logic                               res_valid,
  output dtig_pkg::out_word_t                res
);

  localparam int SW = $clog2(MAX_SIDES + 1);
  localparam int LW = $clog2(MAX_LEVELS + 1);
  localparam int IW = dtig_pkg::IDX_W;

  typedef enum logic [2:0] {
    PH_IDLE = 3'b001,
    PH_BODY = 3'b010,
    PH_CAP  = 3'b100
  } phase_t;

  logic [dtig_pkg::SIDES_W-1:0]  sides;
  logic [dtig_pkg::LEVELS_W-1:0] levels;
  logic [LW-1:0]                 row, row_next;
  logic [SW-1:0]                 column, column_next;
  phase_t                        phase, phase_next;
  logic [IW-1:0]                 base_vertex;
  logic [IW-1:0]                 next_slot, next_slot_next;

  logic [SW-1:0] s;
  logic [LW-1:0] l;
  logic [IW-1:0] s16, l16, ring_total;
  logic          start;
  phase_t        ph0, ph1;
  logic [LW-1:0] row0, row_inc;
  logic [SW-1:0] col0, col1, col2, col_inc;
  logic [IW-1:0] base0, slot0;
  logic          body, last_col, diag;
  logic [IW-1:0] row_mul, sw_i, nw_i, se_i, ne_i, apex;

  // Clamp the registers into their meaningful ranges
  always_comb begin
    if (IW'(sides) < IW'(3)) begin
      s = SW'(3);
    end else if (IW'(sides) > IW'(MAX_SIDES)) begin
      s = SW'(MAX_SIDES);
    end else begin
      s = SW'(sides);
    end
    if (levels == '0) begin
      l = LW'(1);
    end else if (IW'(levels) > IW'(MAX_LEVELS)) begin
      l = LW'(MAX_LEVELS);
    end else begin
      l = LW'(levels);
    end
  end

  assign s16        = IW'(s);
  assign l16        = IW'(l);
  assign ring_total = (l16 + IW'(1)) * s16;
  assign start      = (in_word.op == dtig_pkg::OP_START);

  // A start word overrides the walk position
  assign ph0   = start ? PH_BODY : phase;
  assign row0  = start ? '0 : row;
  assign col0  = start ? '0 : column;
  assign base0 = start ? (in_word.pass ? ring_total + IW'(1) : '0) : base_vertex;
  assign slot0 = start ? in_word.first_slot : next_slot;

  always_comb begin
    if (ph0 == PH_BODY && row0 >= l) begin
      ph1  = PH_CAP;
      col1 = '0;
    end else begin
      ph1  = ph0;
      col1 = col0;
    end
  end

  assign col2     = (col1 >= s) ? s - SW'(1) : col1;
  assign body     = (ph1 == PH_BODY);
  assign last_col = (col2 == s - SW'(1));
  assign diag     = (row0[0] == col2[0]);
  assign row_mul  = body ? IW'(row0) : l16;
  assign sw_i     = base0 + row_mul * s16 + IW'(col2);
  assign nw_i     = sw_i + s16;
  assign se_i     = last_col ? sw_i + IW'(1) - s16 : sw_i + IW'(1);
  assign ne_i     = se_i + s16;
  assign apex     = base0 + ring_total;

  assign res_valid = (ph0 != PH_IDLE);

  always_comb begin
    res            = '0;
    res.group_size = body;
    res.slot       = slot0;
    res.last       = !body && last_col;
    if (body) begin
      if (diag) begin
        res.idx_a = sw_i; res.idx_b = ne_i; res.idx_c = nw_i;
        res.idx_d = sw_i; res.idx_e = se_i; res.idx_f = ne_i;
      end else begin
        res.idx_a = sw_i; res.idx_b = se_i; res.idx_c = nw_i;
        res.idx_d = se_i; res.idx_e = ne_i; res.idx_f = nw_i;
      end
    end else begin
      res.idx_a = sw_i; res.idx_b = se_i; res.idx_c = apex;
    end
  end

  assign col_inc = col2 + SW'(1);
  assign row_inc = row0 + LW'(1);

  // Advance to the next cell, row or phase
  always_comb begin
    next_slot_next = slot0 + (body ? IW'(6) : IW'(3));
    phase_next     = ph1;
    row_next       = row0;
    column_next    = col_inc;
    if (last_col) begin
      column_next = '0;
      if (body) begin
        if (row_inc >= l) begin
          phase_next = PH_CAP;
          row_next   = '0;
        end else begin
          row_next = row_inc;
        end
      end else begin
        phase_next = PH_IDLE;
        row_next   = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sides       <= dtig_pkg::SIDES_RESET;
      levels      <= dtig_pkg::LEVELS_RESET;
      row         <= '0;
      column      <= '0;
      phase       <= PH_IDLE;
      base_vertex <= '0;
      next_slot   <= '0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          dtig_pkg::REG_SIDES:  sides  <= cfg_data[dtig_pkg::SIDES_W-1:0];
          dtig_pkg::REG_LEVELS: levels <= cfg_data[dtig_pkg::LEVELS_W-1:0];
          default: ;
        endcase
      end
      if (step && res_valid) begin
        row         <= row_next;
        column      <= column_next;
        phase       <= phase_next;
        base_vertex <= base0;
        next_slot   <= next_slot_next;
      end
    end
  end

  a_last_goes_idle: assert property (@(posedge clk) disable iff (rst)
    step && res_valid && res.last |=> phase == PH_IDLE)
    else $error("walk not idle after final group");

  a_start_runs: assert property (@(posedge clk) disable iff (rst)
    step && start |-> res_valid)
    else $error("start word gave no group");

  a_hold_when_no_step: assert property (@(posedge clk) disable iff (rst)
    !step |=> $stable(phase) && $stable(next_slot) && $stable(column))
    else $error("walk state moved without a word");

endmodule

`default_nettype wire

@@ rtl/dtig_out_stage.sv @@
// Dome triangle index generator: output register for the result word.
// Depends on dtig_pkg.
`default_nettype none

module dtig_out_stage (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                load,
  input  wire dtig_pkg::out_word_t res,
  input  wire logic                out_stall,
  output logic                     out_valid,
  output dtig_pkg::out_word_t      out_word,
  output logic                     busy
);

  // Upstream waits only while a held word is stalled
  assign busy = out_valid && out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_word <= res;
    end
  end

endmodule

`default_nettype wire

@@ rtl/dome_triangle_index_generator_core.sv @@
// Dome triangle index generator: top level.
// Depends on dtig_pkg, dtig_walk and dtig_out_stage.
//
// Input channel (in_valid / in_stall / in_word): a start word (op set)
// fixes the dome copy and first buffer slot and yields the first group;
// each advance word yields the next group. Advance words while no dome is
// running are taken and dropped without a result.
// Output channel (out_valid / out_stall / out_word): one index group per
// word, six indices for a body cell, three for a cap triangle, with its
// buffer slot; the final cap group carries last.
// Configuration: cfg_wr_en with cfg_index 0 (sides) or 1 (levels) and
// cfg_data; write only while idle.
// out_word shows a group in the cycle after its input word is accepted, and
// one word per cycle is sustained while out_stall is low: the group is
// formed by a multiply and adds between the walk and output registers.
// Reset returns the walk to idle with sides 16 and levels 8.
// While out_stall holds a word, in_stall is raised and nothing is lost.
`default_nettype none

module dome_triangle_index_generator_core #(
  parameter int MAX_SIDES  = dtig_pkg::MAX_SIDES_DEF,
  parameter int MAX_LEVELS = dtig_pkg::MAX_LEVELS_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       cfg_wr_en,
  input  wire logic                       cfg_index,
  input  wire logic [dtig_pkg::CFG_W-1:0] cfg_data,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire dtig_pkg::in_word_t         in_word,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output dtig_pkg::out_word_t             out_word
);

  logic                in_accept;
  logic                res_valid;
  dtig_pkg::out_word_t res;

  assign in_accept = in_valid && !in_stall;

  dtig_walk #(
    .MAX_SIDES  (MAX_SIDES),
    .MAX_LEVELS (MAX_LEVELS)
  ) u_walk (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .step      (in_accept),
    .in_word   (in_word),
    .res_valid (res_valid),
    .res       (res)
  );

  dtig_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (in_accept && res_valid),
    .res       (res),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_word  (out_word),
    .busy      (in_stall)
  );

endmodule

`default_nettype wire

@@ test/tb.sv @@
// Testbench for dome_triangle_index_generator_core: directed and random domes.
// Depends on dtig_pkg and the core RTL only. Driver and monitor are clocked processes fed
// from queues; each output group is checked field by field against the predicted group.
`timescale 1ns / 100ps

module tb;

  localparam int MAX_S        = dtig_pkg::MAX_SIDES_DEF;
  localparam int MAX_L        = dtig_pkg::MAX_LEVELS_DEF;
  localparam int ITEM_TARGET  = 1650;
  localparam int SETTLE       = 4;
  localparam int QUIET_LIMIT  = 3000;
  localparam int HOLD_CYCLES  = 150;

  typedef enum logic [2:0] {
    WALK_IDLE = 3'b001,
    WALK_BODY = 3'b010,
    WALK_CAP  = 3'b100
  } walk_phase_t;

  logic                          clk       = 1'b0;
  logic                          rst       = 1'b1;
  logic                          cfg_wr_en = 1'b0;
  logic                          cfg_index = dtig_pkg::REG_SIDES;
  logic [dtig_pkg::CFG_W-1:0]    cfg_data  = '0;
  logic                          in_valid  = 1'b0;
  logic                          in_stall;
  dtig_pkg::in_word_t            in_word   = '0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  dtig_pkg::out_word_t           out_word;

  // model copy of registers and walk state
  logic [dtig_pkg::SIDES_W-1:0]  cfg_sides;
  logic [dtig_pkg::LEVELS_W-1:0] cfg_levels;
  walk_phase_t                   walk_phase;
  int unsigned                   walk_row;
  int unsigned                   walk_col;
  logic [dtig_pkg::IDX_W-1:0]    base_vtx;
  logic [dtig_pkg::IDX_W-1:0]    slot_next;

  dtig_pkg::in_word_t  word_q[$];
  dtig_pkg::out_word_t group_q[$];

  int err_count  = 0;
  int n_sent     = 0;
  int n_checked  = 0;
  int domes_done = 0;
  int n_writes   = 0;
  int n_holds    = 0;
  int seq_items  = 0;
  int burst_left = 0;
  int gap_left   = 0;
  int hold_left  = 0;
  int seg_left   = 0;
  int stall_pct  = 0;

  dome_triangle_index_generator_core dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int unsigned eff_sides(input logic [dtig_pkg::SIDES_W-1:0] raw);
    if (raw < 3) return 3;
    if (raw > MAX_S) return MAX_S;
    return raw;
  endfunction

  function automatic int unsigned eff_levels(input logic [dtig_pkg::LEVELS_W-1:0] raw);
    if (raw < 1) return 1;
    if (raw > MAX_L) return MAX_L;
    return raw;
  endfunction

  // Advance the walk by one accepted word and queue the group it yields, if any.
  task automatic form_group(input dtig_pkg::in_word_t w);
    int unsigned         s, l, sw, nw, se, ne;
    logic                is_body;
    dtig_pkg::out_word_t g;
    s = eff_sides(cfg_sides);
    l = eff_levels(cfg_levels);
    if (w.op == dtig_pkg::OP_START) begin
      base_vtx   = w.pass ? dtig_pkg::IDX_W'((l + 1) * s + 1) : '0;
      slot_next  = w.first_slot;
      walk_phase = WALK_BODY;
      walk_row   = 0;
      walk_col   = 0;
    end
    if (walk_phase != WALK_BODY && walk_phase != WALK_CAP) return;
    // registers may have shrunk under a running dome
    if (walk_phase == WALK_BODY && walk_row >= l) begin
      walk_phase = WALK_CAP;
      walk_col   = 0;
    end
    if (walk_col >= s) walk_col = s - 1;
    is_body = (walk_phase == WALK_BODY);
    sw = base_vtx + (is_body ? walk_row : l) * s + walk_col;
    nw = sw + s;
    se = (walk_col == s - 1) ? sw + 1 - s : sw + 1;
    ne = se + s;
    g = '0;
    if (is_body) begin
      g.idx_a = dtig_pkg::IDX_W'(sw);
      g.idx_c = dtig_pkg::IDX_W'(nw);
      if ((walk_row % 2) == (walk_col % 2)) begin
        g.idx_b = dtig_pkg::IDX_W'(ne);
        g.idx_d = dtig_pkg::IDX_W'(sw);
        g.idx_e = dtig_pkg::IDX_W'(se);
        g.idx_f = dtig_pkg::IDX_W'(ne);
      end else begin
        g.idx_b = dtig_pkg::IDX_W'(se);
        g.idx_d = dtig_pkg::IDX_W'(se);
        g.idx_e = dtig_pkg::IDX_W'(ne);
        g.idx_f = dtig_pkg::IDX_W'(nw);
      end
    end else begin
      g.idx_a = dtig_pkg::IDX_W'(sw);
      g.idx_b = dtig_pkg::IDX_W'(se);
      g.idx_c = dtig_pkg::IDX_W'(base_vtx + (l + 1) * s);
    end
    g.group_size = is_body;
    g.slot       = slot_next;
    g.last       = !is_body && (walk_col == s - 1);
    group_q.push_back(g);
    if (g.last) domes_done++;
    slot_next = slot_next + (is_body ? dtig_pkg::IDX_W'(6) : dtig_pkg::IDX_W'(3));
    walk_col++;
    if (walk_col >= s) begin
      walk_col = 0;
      if (is_body) begin
        walk_row++;
        if (walk_row >= l) begin
          walk_phase = WALK_CAP;
          walk_row   = 0;
        end
      end else begin
        walk_phase = WALK_IDLE;
        walk_row   = 0;
      end
    end
  endtask

  task automatic check_field(input string name, input logic [dtig_pkg::IDX_W-1:0] want,
                             input logic [dtig_pkg::IDX_W-1:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      err_count++;
    end
  endtask

  // Input side: present queued words in bursts with gaps; hold a stalled word.
  always @(posedge clk) begin : send_side
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        form_group(in_word);
        n_sent++;
      end
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (word_q.size() == 0) begin
          in_valid <= 1'b0;
        end else begin
          in_valid <= 1'b1;
          in_word  <= word_q.pop_front();
          if (burst_left > 0) burst_left--;
          if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 24);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end
        end
      end
    end
  end

  // Output side: check each accepted group and stall on a pattern of its own.
  always @(posedge clk) begin : recv_side
    dtig_pkg::out_word_t want;
    logic                stall_next;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (group_q.size() == 0) begin
          $error("group at slot %0h with nothing expected", out_word.slot);
          err_count++;
        end else begin
          want = group_q.pop_front();
          check_field("idx_a", want.idx_a, out_word.idx_a);
          check_field("idx_b", want.idx_b, out_word.idx_b);
          check_field("idx_c", want.idx_c, out_word.idx_c);
          check_field("idx_d", want.idx_d, out_word.idx_d);
          check_field("idx_e", want.idx_e, out_word.idx_e);
          check_field("idx_f", want.idx_f, out_word.idx_f);
          check_field("group_size", dtig_pkg::IDX_W'(want.group_size),
                      dtig_pkg::IDX_W'(out_word.group_size));
          check_field("slot", want.slot, out_word.slot);
          check_field("last", dtig_pkg::IDX_W'(want.last), dtig_pkg::IDX_W'(out_word.last));
          n_checked++;
        end
      end
      // long hold-off so the core fills and stalls its input
      if (hold_left == 0 && n_holds < 2 && n_checked >= 300 + n_holds * 800) begin
        hold_left = HOLD_CYCLES;
        n_holds++;
      end
      if (hold_left > 0) begin
        hold_left--;
        stall_next = 1'b1;
      end else begin
        if (seg_left == 0) begin
          seg_left = $urandom_range(10, 150);
          case ($urandom_range(0, 4))
            2: stall_pct = 20;
            3: stall_pct = 50;
            4: stall_pct = 85;
            default: stall_pct = 0;
          endcase
        end
        seg_left--;
        stall_next = ($urandom_range(0, 99) < stall_pct);
      end
      out_stall <= stall_next;
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("tb: FAIL");
    $finish;
  end

  // Wait until every queued word is taken and every group has come back.
  task automatic drain();
    do @(negedge clk);
    while (word_q.size() != 0 || in_valid || group_q.size() != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [dtig_pkg::CFG_W-1:0] val);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    if (idx == dtig_pkg::REG_SIDES) cfg_sides = val[dtig_pkg::SIDES_W-1:0];
    else cfg_levels = val[dtig_pkg::LEVELS_W-1:0];
    n_writes++;
  endtask

  // Drain, then write one or both registers; a negative value leaves one untouched.
  task automatic settings(input int sides_v, input int levels_v);
    drain();
    if (sides_v >= 0 && levels_v >= 0 && $urandom_range(0, 1)) begin
      write_reg(dtig_pkg::REG_LEVELS, dtig_pkg::CFG_W'(levels_v));
      write_reg(dtig_pkg::REG_SIDES, dtig_pkg::CFG_W'(sides_v));
    end else begin
      if (sides_v >= 0) write_reg(dtig_pkg::REG_SIDES, dtig_pkg::CFG_W'(sides_v));
      if (levels_v >= 0) write_reg(dtig_pkg::REG_LEVELS, dtig_pkg::CFG_W'(levels_v));
    end
    @(negedge clk);
  endtask

  task automatic push_word(input logic op, input logic pass,
                           input logic [dtig_pkg::IDX_W-1:0] fs);
    dtig_pkg::in_word_t w;
    w.op         = op;
    w.pass       = pass;
    w.first_slot = fs;
    word_q.push_back(w);
    seq_items++;
  endtask

  // A start followed by advances; advance words carry random junk in the unused fields.
  task automatic push_dome(input logic pass, input logic [dtig_pkg::IDX_W-1:0] fs,
                           input int n_adv);
    push_word(dtig_pkg::OP_START, pass, fs);
    repeat (n_adv) push_word(dtig_pkg::OP_ADVANCE, 1'($urandom), dtig_pkg::IDX_W'($urandom));
  endtask

  initial begin : stimulus
    int s_raw, l_raw, dlen, kind, n;
    cfg_sides  = dtig_pkg::SIDES_RESET;
    cfg_levels = dtig_pkg::LEVELS_RESET;
    walk_phase = WALK_IDLE;
    walk_row   = 0;
    walk_col   = 0;
    base_vtx   = '0;
    slot_next  = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: advance with no dome running is dropped
    push_word(dtig_pkg::OP_ADVANCE, 1'b1, 16'hFFFF);
    // 8 x 4 dome from the second copy, slot wrapping past the top
    settings(8, 4);
    push_dome(1'b1, 16'hFFF0, 12);
    // shrink sides under the running dome: column clamps to the last one
    settings(3, -1);
    repeat (3) push_word(dtig_pkg::OP_ADVANCE, 1'b0, 16'h0000);
    // shrink levels: the walk jumps to the cap, last advance is dropped
    settings(-1, 1);
    repeat (4) push_word(dtig_pkg::OP_ADVANCE, 1'b0, 16'hFFFF);
    // restart while a dome is running
    push_dome(1'b0, 16'h0000, 1);
    push_dome(1'b1, 16'h7FFF, 1);

    // extremes of the registers
    settings(127, 127);
    push_dome(1'b1, 16'hFFFE, 150);
    settings(64, 1);
    push_dome(1'b1, 16'h8001, 127);
    push_word(dtig_pkg::OP_ADVANCE, 1'b1, 16'h1234);
    settings(0, 0);
    push_dome(1'b0, 16'hFFFD, 5);
    push_word(dtig_pkg::OP_ADVANCE, 1'b0, 16'h0000);

    while (seq_items < ITEM_TARGET) begin
      case ($urandom_range(0, 9))
        0: s_raw = $urandom_range(0, 2);
        1: s_raw = $urandom_range(64, 127);
        2: s_raw = $urandom_range(9, 63);
        default: s_raw = $urandom_range(3, 8);
      endcase
      case ($urandom_range(0, 9))
        0: l_raw = 0;
        1: l_raw = $urandom_range(32, 63);
        2: l_raw = $urandom_range(5, 31);
        default: l_raw = $urandom_range(1, 4);
      endcase
      l_raw = l_raw | ($urandom_range(0, 1) << dtig_pkg::LEVELS_W);
      settings(s_raw, l_raw);
      dlen = eff_sides(cfg_sides) * eff_levels(cfg_levels) + eff_sides(cfg_sides);
      repeat ($urandom_range(2, 6)) begin
        if (seq_items < ITEM_TARGET) begin
          kind = $urandom_range(0, 9);
          if (kind < 6) begin
            n = (dlen <= 300) ? dlen - 1 : $urandom_range(20, 200);
            push_dome(1'($urandom), dtig_pkg::IDX_W'($urandom), n);
          end else if (kind < 8) begin
            // broken off part way, abandoned by the next start or the phase end
            n = $urandom_range(0, (dlen - 1 < 200) ? dlen - 1 : 200);
            push_dome(1'($urandom), dtig_pkg::IDX_W'($urandom), n);
          end else if (kind == 8) begin
            n = (dlen <= 300) ? dlen - 1 : $urandom_range(20, 200);
            push_dome(1'($urandom), dtig_pkg::IDX_W'($urandom), n);
            repeat ($urandom_range(1, 4))
              push_word(dtig_pkg::OP_ADVANCE, 1'($urandom), dtig_pkg::IDX_W'($urandom));
          end else begin
            repeat ($urandom_range(1, 10))
              push_word(($urandom_range(0, 3) == 0) ? dtig_pkg::OP_START
                                                    : dtig_pkg::OP_ADVANCE,
                        1'($urandom), dtig_pkg::IDX_W'($urandom));
          end
        end
      end
    end

    drain();
    $display("summary: %0d words sent, %0d groups checked, %0d domes finished",
             n_sent, n_checked, domes_done);
    $display("summary: %0d register writes, %0d long output hold-offs, %0d errors",
             n_writes, n_holds, err_count);
    if (err_count == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/dtig_pkg.sv
rtl/dtig_walk.sv
rtl/dtig_out_stage.sv
rtl/dome_triangle_index_generator_core.sv
test/tb.sv
